### rtl/hrlc_pkg.sv
// shared types, codes and helpers for the http request line checker
package hrlc_pkg;

  localparam int unsigned DATA_W  = 8;
  localparam int unsigned LIMIT_W = 16;
  localparam int unsigned COUNT_W = 17;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd8192;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 17'h1FFFF;

  localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;
  localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CH_SLASH = 8'h2F;

  localparam logic [3:0] VPOS_LEN   = 4'd8;
  localparam logic [3:0] VPOS_SAT   = 4'd9;
  localparam logic [3:0] VPOS_EXTRA = 4'd15;

  typedef enum logic [1:0] {
    TOK_NONE    = 2'd0,
    TOK_METHOD  = 2'd1,
    TOK_URI     = 2'd2,
    TOK_VERSION = 2'd3
  } tok_t;

  typedef enum logic [2:0] {
    TAG_SPACE   = 3'd0,
    TAG_METHOD  = 3'd1,
    TAG_URI     = 3'd2,
    TAG_VERSION = 3'd3,
    TAG_EXTRA   = 3'd4
  } tag_t;

  typedef enum logic [2:0] {
    ST_PENDING     = 3'd0,
    ST_COMPLETE    = 3'd1,
    ST_TOO_LARGE   = 3'd2,
    ST_MALFORMED   = 3'd3,
    ST_BAD_URI     = 3'd4,
    ST_BAD_VERSION = 3'd5
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0]  echo_byte;
    tag_t               field_tag;
    status_t            status;
    logic [LIMIT_W-1:0] line_length;
  } result_t;

  function automatic logic [DATA_W-1:0] version_char(input logic [2:0] pos);
    logic [DATA_W-1:0] c;
    unique case (pos)
      3'd0: c = 8'h48;
      3'd1: c = 8'h54;
      3'd2: c = 8'h54;
      3'd3: c = 8'h50;
      3'd4: c = 8'h2F;
      3'd5: c = 8'h31;
      3'd6: c = 8'h2E;
      3'd7: c = 8'h31;
      default: c = 8'h31;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [DATA_W-1:0] b);
    return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

endpackage

### rtl/hrlc_parse.sv
// per-line parse state and the single-pass byte classification logic
module hrlc_parse
  import hrlc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [DATA_W-1:0]  data_byte,
  input  logic [LIMIT_W-1:0] max_line_bytes,
  output result_t            result
);

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               prev_cr_r, prev_cr_nxt;
  tok_t               tok_r, tok_nxt;
  logic               inside_r, inside_nxt;
  logic               slash_r, slash_nxt;
  logic [3:0]         vpos_r, vpos_nxt;
  logic               vmis_r, vmis_nxt;

  always_comb begin
    logic    term;
    logic    vb;
    tag_t    tag;
    status_t st;

    term        = (data_byte == CH_LF) && prev_cr_r;
    count_nxt   = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;
    tok_nxt     = tok_r;
    inside_nxt  = inside_r;
    slash_nxt   = slash_r;
    vpos_nxt    = vpos_r;
    vmis_nxt    = vmis_r;
    vb          = 1'b0;
    tag         = TAG_SPACE;

    if (is_space(data_byte)) begin
      if (inside_r && tok_r == TOK_VERSION && vpos_r != VPOS_EXTRA && vpos_r != VPOS_LEN) begin
        vmis_nxt = 1'b1;
      end
      inside_nxt = 1'b0;
    end else begin
      if (!inside_r) begin
        unique case (tok_r)
          TOK_NONE: begin
            tok_nxt = TOK_METHOD;
          end
          TOK_METHOD: begin
            tok_nxt   = TOK_URI;
            slash_nxt = (data_byte == CH_SLASH);
          end
          TOK_URI: begin
            tok_nxt  = TOK_VERSION;
            vpos_nxt = '0;
            vb       = 1'b1;
          end
          TOK_VERSION: begin
            if (vpos_r != VPOS_EXTRA && vpos_r != VPOS_LEN) begin
              vmis_nxt = 1'b1;
            end
            vpos_nxt = VPOS_EXTRA;
          end
          default: ;
        endcase
        inside_nxt = 1'b1;
      end else if (tok_r == TOK_VERSION && vpos_r != VPOS_EXTRA) begin
        vb = 1'b1;
      end
      if (vb) begin
        if (vpos_nxt < VPOS_LEN) begin
          if (data_byte != version_char(vpos_nxt[2:0])) begin
            vmis_nxt = 1'b1;
          end
        end else begin
          vmis_nxt = 1'b1;
        end
        if (vpos_nxt < VPOS_SAT) begin
          vpos_nxt = vpos_nxt + 1'b1;
        end
      end
      if (tok_nxt == TOK_VERSION && vpos_nxt == VPOS_EXTRA) begin
        tag = TAG_EXTRA;
      end else begin
        tag = tag_t'({1'b0, tok_nxt});
      end
    end
    prev_cr_nxt = (data_byte == CH_CR);

    st = ST_PENDING;
    result.line_length = '0;
    if (count_nxt > {1'b0, max_line_bytes}) begin
      st = ST_TOO_LARGE;
    end else if (term) begin
      if (tok_nxt != TOK_VERSION) begin
        st = ST_MALFORMED;
      end else if (!slash_nxt) begin
        st = ST_BAD_URI;
      end else if (vmis_nxt) begin
        st = ST_BAD_VERSION;
      end else begin
        st = ST_COMPLETE;
        result.line_length = count_nxt[LIMIT_W-1:0];
      end
    end

    if (st != ST_PENDING) begin
      count_nxt   = '0;
      prev_cr_nxt = 1'b0;
      tok_nxt     = TOK_NONE;
      inside_nxt  = 1'b0;
      slash_nxt   = 1'b0;
      vpos_nxt    = '0;
      vmis_nxt    = 1'b0;
    end

    result.echo_byte = data_byte;
    result.field_tag = tag;
    result.status    = st;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      prev_cr_r <= 1'b0;
      tok_r     <= TOK_NONE;
      inside_r  <= 1'b0;
      slash_r   <= 1'b0;
      vpos_r    <= '0;
      vmis_r    <= 1'b0;
    end else if (step) begin
      count_r   <= count_nxt;
      prev_cr_r <= prev_cr_nxt;
      tok_r     <= tok_nxt;
      inside_r  <= inside_nxt;
      slash_r   <= slash_nxt;
      vpos_r    <= vpos_nxt;
      vmis_r    <= vmis_nxt;
    end
  end

endmodule

### rtl/hrlc_out.sv
// result register with valid and stall towards the sink
module hrlc_out
  import hrlc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load_valid,
  input  result_t load_data,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign can_load  = !valid_r || !out_stall;
  assign valid_nxt = can_load ? load_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### rtl/http_request_line_checker_top.sv
// path: input register, then parse logic, then the result register driving the out_ ports
// throughput: one beat per cycle while out_stall does not hold the result register, set by
// the single-pass parse logic between the input register and the result register
// reset: synchronous active-low rst_n empties both registers, clears the line state and
// sets max_line_bytes to 8192
module http_request_line_checker_top
  import hrlc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DATA_W-1:0]  in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DATA_W-1:0]  out_echo_byte,
  output logic [2:0]         out_field_tag,
  output logic [2:0]         out_status,
  output logic [LIMIT_W-1:0] out_line_length,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_max_line_bytes
);

  logic [LIMIT_W-1:0] limit_r;
  logic               in_valid_r, in_valid_nxt;
  logic [DATA_W-1:0]  in_byte_r;
  logic               can_load;
  logic               step;
  result_t            res;
  result_t            out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_max_line_bytes;
    end
  end

  // input stage moves on whenever the result register can take its beat
  assign step         = in_valid_r && can_load;
  assign in_stall     = in_valid_r && !can_load;
  assign in_valid_nxt = (!in_valid_r || can_load) ? in_valid : in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_data_byte;
    end
  end

  hrlc_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .data_byte      (in_byte_r),
    .max_line_bytes (limit_r),
    .result         (res)
  );

  hrlc_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_valid_r),
    .load_data  (res),
    .can_load   (can_load),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_res)
  );

  assign out_echo_byte   = out_res.echo_byte;
  assign out_field_tag   = out_res.field_tag;
  assign out_status      = out_res.status;
  assign out_line_length = out_res.line_length;

endmodule

### rtl/hrlc_checker.sv
// port-level assertions for the request line checker and their bind
module hrlc_checker
  import hrlc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DATA_W-1:0]  out_echo_byte,
  input logic [2:0]         out_field_tag,
  input logic [2:0]         out_status,
  input logic [LIMIT_W-1:0] out_line_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_echo_byte) && $stable(out_status))
    else $error("stalled result beat changed");

  a_len_only_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_COMPLETE |-> out_line_length == '0)
    else $error("line length given without complete status");

  a_complete_on_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_COMPLETE
      |-> out_echo_byte == CH_LF && out_field_tag == TAG_SPACE && out_line_length >= 16'd11)
    else $error("complete status on a beat that is not a terminator");

  a_codes_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_field_tag <= TAG_EXTRA && out_status <= ST_BAD_VERSION)
    else $error("tag or status code out of range");

endmodule

bind http_request_line_checker_top hrlc_checker u_hrlc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_echo_byte   (out_echo_byte),
  .out_field_tag   (out_field_tag),
  .out_status      (out_status),
  .out_line_length (out_line_length)
);

### sim/tb_http_request_line_checker_top.sv
// testbench for the http request line checker: random request lines against an inline parse model
module tb_http_request_line_checker_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hrlc_pkg::*;

  localparam logic [7:0] B_TAB   = 8'h09;
  localparam logic [7:0] B_LF    = 8'h0A;
  localparam logic [7:0] B_VT    = 8'h0B;
  localparam logic [7:0] B_FF    = 8'h0C;
  localparam logic [7:0] B_CR    = 8'h0D;
  localparam logic [7:0] B_SP    = 8'h20;
  localparam logic [7:0] B_SLASH = 8'h2F;

  localparam logic [16:0] LINE_COUNT_MAX = 17'h1FFFF;
  localparam logic [63:0] VERSION_TEXT   = "HTTP/1.1";
  localparam logic [3:0]  VER_LEN        = 4'd8;
  localparam logic [3:0]  VER_SAT        = 4'd9;
  localparam logic [3:0]  VER_EXTRA      = 4'd15;
  localparam int          STALL_LIMIT    = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [DATA_W-1:0] in_data_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_W-1:0] out_echo_byte;
  logic [2:0] out_field_tag;
  logic [2:0] out_status;
  logic [LIMIT_W-1:0] out_line_length;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LIMIT_W-1:0] cfg_max_line_bytes = '0;

  always #4 clk = ~clk;

  http_request_line_checker_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_echo_byte      (out_echo_byte),
    .out_field_tag      (out_field_tag),
    .out_status         (out_status),
    .out_line_length    (out_line_length),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_max_line_bytes (cfg_max_line_bytes)
  );

  // parse state mirrored from the block
  logic [LIMIT_W-1:0] limit_q = 16'd8192;
  logic [16:0] line_bytes = '0;
  logic saw_cr = 1'b0;
  tok_t tok = TOK_NONE;
  logic in_tok = 1'b0;
  logic uri_slash = 1'b0;
  logic [3:0] vpos = '0;
  logic ver_bad = 1'b0;

  logic [7:0] request_bytes[$];
  result_t results_due[$];

  bit beat_pending = 1'b0;
  bit drain_hold = 1'b0;
  bit calm = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int stuck = 0;
  int failures = 0;
  int beats_seen = 0;
  int cfg_writes = 0;
  int status_seen[8] = '{default: 0};
  int unsigned pushed = 0;
  logic [7:0] last_pushed = 8'h00;

  function automatic logic is_ws(input logic [7:0] b);
    return b == B_SP || (b >= B_TAB && b <= B_CR);
  endfunction

  function automatic void version_step(input logic [7:0] b);
    if (vpos < VER_LEN) begin
      if (b != VERSION_TEXT[63 - 8 * int'(vpos) -: 8]) ver_bad = 1'b1;
    end else begin
      ver_bad = 1'b1;
    end
    if (vpos < VER_SAT) vpos++;
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    logic term;
    term = (b == B_LF) && saw_cr;
    r.echo_byte = b;
    r.field_tag = TAG_SPACE;
    r.status = ST_PENDING;
    r.line_length = '0;
    if (line_bytes != LINE_COUNT_MAX) line_bytes++;
    if (is_ws(b)) begin
      if (in_tok && tok == TOK_VERSION && vpos != VER_EXTRA && vpos != VER_LEN) ver_bad = 1'b1;
      in_tok = 1'b0;
    end else begin
      if (!in_tok) begin
        case (tok)
          TOK_NONE: tok = TOK_METHOD;
          TOK_METHOD: begin
            tok = TOK_URI;
            uri_slash = (b == B_SLASH);
          end
          TOK_URI: begin
            tok = TOK_VERSION;
            vpos = '0;
            version_step(b);
          end
          default: begin
            if (vpos != VER_EXTRA && vpos != VER_LEN) ver_bad = 1'b1;
            vpos = VER_EXTRA;
          end
        endcase
        in_tok = 1'b1;
      end else if (tok == TOK_VERSION && vpos != VER_EXTRA) begin
        version_step(b);
      end
      r.field_tag = (tok == TOK_VERSION && vpos == VER_EXTRA) ? TAG_EXTRA : tag_t'(tok);
    end
    saw_cr = (b == B_CR);
    if (line_bytes > {1'b0, limit_q}) begin
      r.status = ST_TOO_LARGE;
    end else if (term) begin
      if (tok != TOK_VERSION) r.status = ST_MALFORMED;
      else if (!uri_slash) r.status = ST_BAD_URI;
      else if (ver_bad) r.status = ST_BAD_VERSION;
      else begin
        r.status = ST_COMPLETE;
        r.line_length = line_bytes[15:0];
      end
    end
    if (r.status != ST_PENDING) begin
      line_bytes = '0;
      saw_cr = 1'b0;
      tok = TOK_NONE;
      in_tok = 1'b0;
      uri_slash = 1'b0;
      vpos = '0;
      ver_bad = 1'b0;
    end
    return r;
  endfunction

  // input driver
  always @(negedge clk) begin
    if (rst_n && !beat_pending) begin
      if (send_gap != 0) begin
        send_gap--;
      end else if (drain_hold) begin
        if (results_due.size() == 0) drain_hold = 1'b0;
      end else if (request_bytes.size() != 0) begin
        if (!calm && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(1, 14) - 1;
        end else if (!calm && $urandom_range(0, 149) == 0) begin
          drain_hold = 1'b1;
        end else begin
          in_data_byte <= request_bytes.pop_front();
          beat_pending = 1'b1;
        end
      end
    end
    in_valid <= beat_pending;
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst_n && !calm && recv_gap == 0 && $urandom_range(0, 11) == 0)
      recv_gap = $urandom_range(1, 14);
    if (recv_gap != 0) begin
      recv_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin
    result_t want;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        limit_q = cfg_max_line_bytes;
        cfg_writes++;
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        results_due = {results_due, parse_byte(in_data_byte)};
        beat_pending = 1'b0;
        beats_seen++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (results_due.size() == 0) begin
          failures++;
          $display("%0t: unexpected beat, expected none, got byte %h tag %0d status %0d length %0d",
                   $time, out_echo_byte, out_field_tag, out_status, out_line_length);
        end else begin
          want = results_due.pop_front();
          status_seen[want.status]++;
          if (out_echo_byte !== want.echo_byte || out_field_tag !== want.field_tag ||
              out_status !== want.status || out_line_length !== want.line_length) begin
            failures++;
            $display("%0t: expected byte %h tag %0d status %0d length %0d, got byte %h tag %0d status %0d length %0d",
                     $time, want.echo_byte, want.field_tag, want.status, want.line_length,
                     out_echo_byte, out_field_tag, out_status, out_line_length);
          end
        end
      end
      if (moved) stuck = 0;
      else stuck++;
      if (stuck >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, results_due.size());
        $display("http_request_line_checker_top: mismatch");
        $finish;
      end
    end
  end

  task automatic push(input logic [7:0] b);
    request_bytes = {request_bytes, b};
    last_pushed = b;
    pushed++;
  endtask

  function automatic logic [7:0] token_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) begin
      do c = 8'($urandom_range(0, 255)); while (is_ws(c));
    end else begin
      c = 8'($urandom_range(8'h21, 8'h7E));
    end
    return c;
  endfunction

  // whitespace run, lone cr and lf included but never a cr lf pair
  task automatic push_gap(input int n);
    logic [7:0] c;
    repeat (n) begin
      case ($urandom_range(0, 7))
        0: c = B_TAB;
        1: c = B_VT;
        2: c = B_FF;
        3: c = B_CR;
        4: c = B_LF;
        default: c = B_SP;
      endcase
      if (c == B_LF && last_pushed == B_CR) c = B_SP;
      push(c);
    end
  endtask

  task automatic queue_line(input int uri_max);
    int kind;
    int ntok;
    int n;
    int pos;
    logic [63:0] ver;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      n = $urandom_range(1, 20);
      repeat (n) push(8'($urandom_range(0, 255)));
    end else begin
      ntok = (kind == 1) ? $urandom_range(0, 2) : 3;
      if ($urandom_range(0, 7) == 0) push_gap($urandom_range(1, 2));
      if (ntok >= 1) begin
        n = $urandom_range(1, 7);
        repeat (n) push(8'($urandom_range(8'h41, 8'h5A)));
      end
      if (ntok >= 2) begin
        push_gap($urandom_range(0, 3) == 0 ? 2 : 1);
        push($urandom_range(0, 7) == 0 ? token_char() : B_SLASH);
        n = $urandom_range(0, uri_max);
        repeat (n) push(token_char());
      end
      if (ntok >= 3) begin
        push_gap($urandom_range(0, 3) == 0 ? 2 : 1);
        ver = VERSION_TEXT;
        n = 8;
        case ($urandom_range(0, 7))
          0: begin
            pos = $urandom_range(0, 7);
            ver[63 - 8 * pos -: 8] = token_char();
          end
          1: n = $urandom_range(1, 7);
          default: ;
        endcase
        for (int i = 0; i < n; i++) push(ver[63 - 8 * i -: 8]);
        if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 3)) push(token_char());
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 2)) begin
            push_gap(1);
            repeat ($urandom_range(1, 5)) push(token_char());
          end
        end
      end
      if ($urandom_range(0, 3) == 0) push_gap($urandom_range(1, 2));
    end
    push(B_CR);
    push(B_LF);
  endtask

  task automatic fill(input int target, input int uri_max);
    int unsigned start;
    start = pushed;
    while (pushed - start < target) queue_line(uri_max);
  endtask

  task automatic wait_idle();
    while (request_bytes.size() != 0 || beat_pending || results_due.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic run_phase(input logic [15:0] lim, input int target, input int uri_max);
    int n;
    wait_idle();
    n = cfg_writes;
    cfg_max_line_bytes <= lim;
    cfg_valid <= 1'b1;
    while (cfg_writes == n) @(negedge clk);
    cfg_valid <= 1'b0;
    fill(target, uri_max);
  endtask

  initial begin
    string s;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    // complete line with an extra token, nul and 0xff line, lone lf
    s = "A / HTTP/1.1 x";
    for (int i = 0; i < s.len(); i++) push(s[i]);
    push(B_CR);
    push(B_LF);
    push(8'h00);
    push(8'hFF);
    push(B_CR);
    push(B_LF);
    push(B_LF);
    push(B_SP);
    push(B_CR);
    push(B_LF);
    fill(380, 12);
    run_phase(16'd24, 250, 12);
    run_phase(16'd0, 30, 4);
    run_phase(16'd1, 30, 4);
    run_phase(16'd2, 50, 4);
    run_phase(16'hFFFF, 450, 200);
    run_phase(16'($urandom_range(30, 200)), 250, 20);
    calm = 1'b1;
    run_phase(16'($urandom_range(16, 80)), 250, 12);
    wait_idle();
    repeat (8) @(negedge clk);
    $display("%0d bytes checked over %0d limit writes, limits 0, 1, 2, 24 and 65535 among them",
             beats_seen, cfg_writes);
    $display("line ends: %0d complete, %0d too large, %0d malformed, %0d bad uri, %0d bad version",
             status_seen[ST_COMPLETE], status_seen[ST_TOO_LARGE], status_seen[ST_MALFORMED],
             status_seen[ST_BAD_URI], status_seen[ST_BAD_VERSION]);
    if (failures == 0) begin
      $display("http_request_line_checker_top: match");
    end else begin
      $display("http_request_line_checker_top: mismatch");
    end
    $finish;
  end

endmodule

### files.f
rtl/hrlc_pkg.sv
rtl/hrlc_parse.sv
rtl/hrlc_out.sv
rtl/http_request_line_checker_top.sv
rtl/hrlc_checker.sv
sim/tb_http_request_line_checker_top.sv
